// ----- rtl/ddo_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddo_pkg
// Shared types, constants and helpers of the differential drive odometry.
// ----------------------------------------------------------------------------
package ddo_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_LEN     = 24;
  localparam int CORDIC_ITERS = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
  localparam int CNT_W        = $clog2(CORDIC_ITERS + 1);

  localparam int CX_W   = 34;   // cordic datapath width
  localparam int MA_W   = 34;   // multiplier operand a
  localparam int MB_W   = 32;   // multiplier operand b
  localparam int PROD_W = MA_W + MB_W;
  localparam int MRES_W = 34;   // rounded product kept

  localparam logic signed [CX_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic signed [MB_W-1:0] RAD_TO_BAM_Q16  = 32'sd683565276;

  localparam logic [23:0] RPM_TO_SPEED_RST  = 24'd109227;
  localparam logic [23:0] INVERSE_TRACK_RST = 24'd141363;
  localparam logic [23:0] TICK_PERIOD_RST   = 24'd167772;

  localparam logic [1:0] REG_RPM_TO_SPEED  = 2'd0;
  localparam logic [1:0] REG_INVERSE_TRACK = 2'd1;
  localparam logic [1:0] REG_TICK_PERIOD   = 2'd2;

  // RND_0 passes the product through unshifted
  typedef enum logic [2:0] {
    RND_8, RND_13, RND_22, RND_24, RND_32, RND_44, RND_0
  } rnd_t;

  typedef struct packed {
    logic signed [MA_W-1:0] a;
    logic signed [MB_W-1:0] b;
    rnd_t                   sh;
  } mul_req_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SPD, S_ENC1, S_ENC2, S_DH1, S_DH2,
    S_DX1, S_DX2, S_DY1, S_DY2, S_DONE
  } state_t;

  function automatic logic [31:0] atan_lut(input logic [4:0] idx);
    logic [31:0] v;
    begin
      unique case (idx)
        5'd0:  v = 32'h20000000;
        5'd1:  v = 32'h12E4051E;
        5'd2:  v = 32'h09FB385B;
        5'd3:  v = 32'h051111D4;
        5'd4:  v = 32'h028B0D43;
        5'd5:  v = 32'h0145D7E1;
        5'd6:  v = 32'h00A2F61E;
        5'd7:  v = 32'h00517C55;
        5'd8:  v = 32'h0028BE53;
        5'd9:  v = 32'h00145F2F;
        5'd10: v = 32'h000A2F98;
        5'd11: v = 32'h000517CC;
        5'd12: v = 32'h00028BE6;
        5'd13: v = 32'h000145F3;
        5'd14: v = 32'h0000A2FA;
        5'd15: v = 32'h0000517D;
        5'd16: v = 32'h000028BE;
        5'd17: v = 32'h0000145F;
        5'd18: v = 32'h00000A30;
        5'd19: v = 32'h00000518;
        5'd20: v = 32'h0000028C;
        5'd21: v = 32'h00000146;
        5'd22: v = 32'h000000A3;
        5'd23: v = 32'h00000051;
        default: v = 32'h0;
      endcase
      return v;
    end
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [MRES_W-1:0] v);
    logic signed [23:0] r;
    begin
      if (v > 34'sd8388607) r = 24'sh7FFFFF;
      else if (v < -34'sd8388608) r = 24'sh800000;
      else r = v[23:0];
      return r;
    end
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [MRES_W-1:0] v);
    logic signed [15:0] r;
    begin
      if (v > 34'sd32767) r = 16'sh7FFF;
      else if (v < -34'sd32768) r = 16'sh8000;
      else r = v[15:0];
      return r;
    end
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    logic signed [31:0] r;
    begin
      if (v > 33'sd2147483647) r = 32'sh7FFFFFFF;
      else if (v < -33'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
    end
  endfunction

endpackage

// ----- rtl/ddo_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddo_mul
// Shared signed multiplier with round-half-up right shift, registered result.
// ----------------------------------------------------------------------------
module ddo_mul
  import ddo_pkg::*;
(
  input  logic                     clk,
  input  mul_req_t                 req,
  output logic signed [MRES_W-1:0] res_r
);

  logic signed [PROD_W-1:0] prod;
  logic signed [MRES_W-1:0] res_nxt;

  assign prod = PROD_W'(req.a) * PROD_W'(req.b);

  always_comb begin
    unique case (req.sh)
      RND_8:   res_nxt = MRES_W'((prod + (PROD_W'(1) <<< 7))  >>> 8);
      RND_13:  res_nxt = MRES_W'((prod + (PROD_W'(1) <<< 12)) >>> 13);
      RND_22:  res_nxt = MRES_W'((prod + (PROD_W'(1) <<< 21)) >>> 22);
      RND_24:  res_nxt = MRES_W'((prod + (PROD_W'(1) <<< 23)) >>> 24);
      RND_32:  res_nxt = MRES_W'((prod + (PROD_W'(1) <<< 31)) >>> 32);
      RND_44:  res_nxt = MRES_W'((prod + (PROD_W'(1) <<< 43)) >>> 44);
      RND_0:   res_nxt = MRES_W'(prod);
      default: res_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

endmodule

// ----- rtl/ddo_cordic.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddo_cordic
// Iterative rotation-mode cordic, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module ddo_cordic
  import ddo_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [15:0]            angle,
  output logic                   done,
  output logic signed [31:0]     cos_out,
  output logic signed [31:0]     sin_out
);

  logic signed [CX_W-1:0] x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic signed [CX_W-1:0] xs, ys, at;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   run_r, run_nxt, done_r, done_nxt, flip_r, flip_nxt;
  logic                   flip_in;
  logic [15:0]            ang_f;

  // fold into [-90, 90) by a half-turn rotation
  assign flip_in = ((angle + 16'h4000) & 16'h8000) != 16'h0;
  assign ang_f   = flip_in ? (angle ^ 16'h8000) : angle;

  assign xs = x_r >>> cnt_r;
  assign ys = y_r >>> cnt_r;
  assign at = CX_W'(atan_lut(5'(cnt_r)));

  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = done_r;
    flip_nxt = flip_r;
    if (start) begin
      x_nxt    = CORDIC_GAIN_Q30;
      y_nxt    = '0;
      z_nxt    = CX_W'(signed'({ang_f, 16'h0}));
      cnt_nxt  = '0;
      run_nxt  = 1'b1;
      done_nxt = 1'b0;
      flip_nxt = flip_in;
    end else if (run_r) begin
      if (!z_r[CX_W-1]) begin
        x_nxt = x_r - ys;
        y_nxt = y_r + xs;
        z_nxt = z_r - at;
      end else begin
        x_nxt = x_r + ys;
        y_nxt = y_r - xs;
        z_nxt = z_r + at;
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(CORDIC_ITERS - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    flip_r <= flip_nxt;
  end

  assign done    = done_r;
  assign cos_out = flip_r ? 32'(-x_r) : 32'(x_r);
  assign sin_out = flip_r ? 32'(-y_r) : 32'(y_r);

endmodule

// ----- rtl/differential_drive_odometry.sv -----
`timescale 1ns / 1ps
// timing: the cordic of 16 iterations, one per cycle, starts at input accept
// and runs overlapped with the first multiply steps
// flow: one shared multiplier and the iterative cordic serialise the work;
// in_tready is low until the result is taken into the free output register
// reset: synchronous active-low rst_n clears pose and loads default registers
// ----------------------------------------------------------------------------
// differential_drive_odometry
// Dead-reckoning pose update per tick from wheel rpm and gyro yaw rate.
// ----------------------------------------------------------------------------
module differential_drive_odometry
  import ddo_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_addr,
  input  logic [23:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [47:0]  in_tdata,   // left_rpm, right_rpm, gyro_rate
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [119:0] out_tdata,  // x_pos, y_pos, heading_angle, linear_speed, turn_rate
  output logic         out_tuser   // gyro_used
);

  state_t state_r, state_nxt;

  logic [23:0] rpm_r, inv_r, tick_r;

  logic signed [15:0] l_r, r_r, g_r, rate_r, rate_nxt;
  logic               gyro_r;
  logic signed [23:0] speed_r;
  logic [15:0]        dh_r, heading_r;
  logic signed [26:0] dx_r;
  logic signed [31:0] pos_x_r, pos_y_r, pos_x_nxt, pos_y_nxt;

  logic               out_valid_r;
  logic [119:0]       out_data_r;
  logic               out_user_r;

  logic signed [15:0] in_l, in_r;
  logic signed [20:0] l10, r11, r9;
  logic signed [16:0] lr_sum, lr_dif;
  logic               accept, load_out, gyro_in;

  mul_req_t                 req;
  logic signed [MRES_W-1:0] mres;
  logic                     cdone;
  logic signed [31:0]       cos_v, sin_v;

  ddo_mul u_mul (
    .clk   (clk),
    .req   (req),
    .res_r (mres)
  );

  ddo_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (accept),
    .angle   (heading_r),
    .done    (cdone),
    .cos_out (cos_v),
    .sin_out (sin_v)
  );

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign in_l      = in_tdata[15:0];
  assign in_r      = in_tdata[31:16];

  // wheel disagreement test on the raw codes
  assign l10     = 21'(in_l) * 21'sd10;
  assign r11     = 21'(in_r) * 21'sd11;
  assign r9      = 21'(in_r) * 21'sd9;
  assign gyro_in = (l10 > r11) || (l10 < r9);

  assign lr_sum = 17'(l_r) + 17'(r_r);
  assign lr_dif = 17'(r_r) - 17'(l_r);

  assign rate_nxt  = gyro_r ? g_r : sat16(mres);
  assign pos_x_nxt = sat32(33'(pos_x_r) + 33'(dx_r));
  assign pos_y_nxt = sat32(33'(pos_y_r) + 33'(mres));
  assign load_out  = (state_r == S_DONE) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    req.a     = '0;
    req.b     = '0;
    req.sh    = RND_8;
    unique case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_SPD;
      end
      S_SPD: begin
        req.a     = MA_W'(lr_sum);
        req.b     = MB_W'(signed'({1'b0, rpm_r}));
        req.sh    = RND_13;
        state_nxt = S_ENC1;
      end
      S_ENC1: begin
        req.a     = MA_W'(lr_dif);
        req.b     = MB_W'(signed'({1'b0, rpm_r}));
        req.sh    = RND_8;
        state_nxt = S_ENC2;
      end
      S_ENC2: begin
        req.a     = mres;
        req.b     = MB_W'(signed'({1'b0, inv_r}));
        req.sh    = RND_24;
        state_nxt = S_DH1;
      end
      S_DH1: begin
        req.a     = MA_W'(rate_nxt);
        req.b     = MB_W'(signed'({1'b0, tick_r}));
        req.sh    = RND_8;
        state_nxt = S_DH2;
      end
      S_DH2: begin
        req.a     = mres;
        req.b     = RAD_TO_BAM_Q16;
        req.sh    = RND_44;
        state_nxt = S_DX1;
      end
      S_DX1: begin
        // keep the heading step on the product until the cordic has finished
        if (cdone) begin
          req.a     = MA_W'(speed_r);
          req.b     = cos_v;
          req.sh    = RND_22;
          state_nxt = S_DX2;
        end else begin
          req.a  = mres;
          req.b  = MB_W'(1);
          req.sh = RND_0;
        end
      end
      S_DX2: begin
        req.a     = mres;
        req.b     = MB_W'(signed'({1'b0, tick_r}));
        req.sh    = RND_32;
        state_nxt = S_DY1;
      end
      S_DY1: begin
        req.a     = MA_W'(speed_r);
        req.b     = sin_v;
        req.sh    = RND_22;
        state_nxt = S_DY2;
      end
      S_DY2: begin
        req.a     = mres;
        req.b     = MB_W'(signed'({1'b0, tick_r}));
        req.sh    = RND_32;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // hold the last product until the output register is free
        req.a  = mres;
        req.b  = MB_W'(1);
        req.sh = RND_0;
        if (load_out) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rpm_r       <= RPM_TO_SPEED_RST;
      inv_r       <= INVERSE_TRACK_RST;
      tick_r      <= TICK_PERIOD_RST;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      heading_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_RPM_TO_SPEED:  rpm_r  <= cfg_wdata;
          REG_INVERSE_TRACK: inv_r  <= cfg_wdata;
          REG_TICK_PERIOD:   tick_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (load_out) begin
        pos_x_r     <= pos_x_nxt;
        pos_y_r     <= pos_y_nxt;
        heading_r   <= heading_r + dh_r;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      l_r    <= in_tdata[15:0];
      r_r    <= in_tdata[31:16];
      g_r    <= in_tdata[47:32];
      gyro_r <= gyro_in;
    end
    if (state_r == S_ENC1) speed_r <= sat24(mres);
    if (state_r == S_DH1)  rate_r  <= rate_nxt;
    if (state_r == S_DX1)  dh_r    <= mres[15:0];
    if (state_r == S_DY1)  dx_r    <= mres[26:0];
    if (load_out) begin
      out_data_r <= {rate_r, speed_r, heading_r + dh_r, pos_y_nxt, pos_x_nxt};
      out_user_r <= gyro_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule
